@@ hw/rtl/krt_pkg.sv @@
// ============================================================================
// Keyed record table package
// Shared sizes, command and status codes, state encoding and the transfer
// structs of the keyed record table with exchange sort and linear search.
// ============================================================================
package krt_pkg;

    localparam int TABLE_DEPTH  = 4096;
    localparam int KEY_BITS     = 19;
    localparam int PAYLOAD_BITS = 16;
    localparam int IDX_BITS     = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS     = $clog2(TABLE_DEPTH + 1);

    // Command codes carried by each input transfer.
    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_SORT   = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    // Status codes carried by each result transfer.
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_MISS  = 2'd2,
        STAT_RANGE = 2'd3
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SORT_GETI,
        S_SORT_SCAN,
        S_SORT_PUTI,
        S_SRCH,
        S_READ,
        S_RESP
    } t_state;

    // One stored record.
    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_entry;

    // Input transfer payload.
    typedef struct packed {
        t_cmd                    command;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [IDX_BITS-1:0]     index;
    } t_krt_in;

    // Result transfer payload.
    typedef struct packed {
        t_status                 status;
        logic [IDX_BITS-1:0]     found_index;
        logic [KEY_BITS-1:0]     entry_key;
        logic [PAYLOAD_BITS-1:0] entry_payload;
    } t_krt_out;

endpackage

@@ hw/rtl/keyed_record_table_sort_search_unit.sv @@
// ============================================================================
// Keyed record table with exchange sort and linear search
// A single-port-write, single-port-read record memory walked by a small
// sequencer that compares keys as they arrive from the read port.
// ============================================================================
// Usage:
//   The input channel (i_in_valid / o_in_stall / i_in_data) carries one
//   command per transfer: append, sort, search or read. The output channel
//   (o_out_valid / i_out_stall / o_out_data) returns exactly one result per
//   command, in order. One command is worked on at a time; o_in_stall is high
//   while the sequencer is busy.
//   With a free output, each result passes through the sequencer's result
//   register and then the output register: append, and any command answered
//   without a table access, go straight to the result; read waits for the
//   memory read port; search walks one entry per cycle through the memory
//   read port (a sorted table stops early); sort of an unsorted table runs
//   an exchange sort with one compare per cycle on the memory read port.
//   The result sits in an output register, so the next command is taken
//   while a finished result still waits. A stalled result holds; a later
//   result waits in the sequencer until the output register is free.
//   Reset empties the table and marks it sorted; memory contents are not
//   cleared, as only written entries below the count are ever read.
// ============================================================================
module keyed_record_table_sort_search_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  krt_pkg::t_krt_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output krt_pkg::t_krt_out o_out_data
);

    // Record memory.
    krt_pkg::t_entry r_mem [krt_pkg::TABLE_DEPTH];
    krt_pkg::t_entry r_rdata;

    logic                          w_we;
    logic [krt_pkg::IDX_BITS-1:0]  w_waddr;
    krt_pkg::t_entry               w_wdata;
    logic [krt_pkg::IDX_BITS-1:0]  w_raddr;

    // Sequencer and table state.
    krt_pkg::t_state               r_state, n_state;
    logic [krt_pkg::CNT_BITS-1:0]  r_count, n_count;
    logic                          r_sorted, n_sorted;
    logic [krt_pkg::IDX_BITS-1:0]  r_i, n_i;
    logic [krt_pkg::IDX_BITS-1:0]  r_pos, n_pos;
    krt_pkg::t_entry               r_cur, n_cur;
    logic [krt_pkg::KEY_BITS-1:0]  r_key, n_key;
    krt_pkg::t_krt_out             r_res, n_res;
    krt_pkg::t_krt_out             r_out, n_out;
    logic                          r_out_valid, n_out_valid;

    logic [krt_pkg::CNT_BITS-1:0]  w_pos_next;
    logic [krt_pkg::CNT_BITS-1:0]  w_i_next2;
    logic                          w_out_free;

    assign o_in_stall  = (r_state != krt_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_pos_next = {1'b0, r_pos} + krt_pkg::CNT_BITS'(1);
    assign w_i_next2  = {1'b0, r_i} + krt_pkg::CNT_BITS'(2);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Memory write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= krt_pkg::S_IDLE;
            r_count     <= '0;
            r_sorted    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sorted    <= n_sorted;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and index registers.
    always_ff @(posedge i_clk) begin
        r_i   <= n_i;
        r_pos <= n_pos;
        r_cur <= n_cur;
        r_key <= n_key;
        r_res <= n_res;
        r_out <= n_out;
    end

    // Sequencer: next state, memory control and results.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_sorted    = r_sorted;
        n_i         = r_i;
        n_pos       = r_pos;
        n_cur       = r_cur;
        n_key       = r_key;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_we        = 1'b0;
        w_waddr     = r_pos;
        w_wdata     = r_cur;
        w_raddr     = r_pos;

        // The output register empties when its transfer completes.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            krt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_res   = '0;
                    n_state = krt_pkg::S_RESP;
                    unique case (i_in_data.command)
                        krt_pkg::CMD_APPEND: begin
                            n_sorted = 1'b0;
                            if (r_count < krt_pkg::CNT_BITS'(krt_pkg::TABLE_DEPTH)) begin
                                w_we                = 1'b1;
                                w_waddr             = r_count[krt_pkg::IDX_BITS-1:0];
                                w_wdata.key         = i_in_data.key;
                                w_wdata.payload     = i_in_data.payload;
                                n_res.status        = krt_pkg::STAT_OK;
                                n_res.found_index   = r_count[krt_pkg::IDX_BITS-1:0];
                                n_res.entry_key     = i_in_data.key;
                                n_res.entry_payload = i_in_data.payload;
                                n_count             = r_count + krt_pkg::CNT_BITS'(1);
                            end else begin
                                n_res.status = krt_pkg::STAT_FULL;
                            end
                        end
                        krt_pkg::CMD_SORT: begin
                            if (!r_sorted && r_count >= krt_pkg::CNT_BITS'(2)) begin
                                w_raddr = '0;
                                n_i     = '0;
                                n_state = krt_pkg::S_SORT_GETI;
                            end else begin
                                n_sorted     = 1'b1;
                                n_res.status = krt_pkg::STAT_OK;
                            end
                        end
                        krt_pkg::CMD_SEARCH: begin
                            n_key = i_in_data.key;
                            if (r_count == '0) begin
                                n_res.status = krt_pkg::STAT_MISS;
                            end else begin
                                w_raddr = '0;
                                n_pos   = '0;
                                n_state = krt_pkg::S_SRCH;
                            end
                        end
                        krt_pkg::CMD_READ: begin
                            if ({1'b0, i_in_data.index} < r_count) begin
                                w_raddr = i_in_data.index;
                                n_pos   = i_in_data.index;
                                n_state = krt_pkg::S_READ;
                            end else begin
                                n_res.status = krt_pkg::STAT_RANGE;
                            end
                        end
                        default: begin
                            n_res.status = krt_pkg::STAT_RANGE;
                        end
                    endcase
                end
            end

            // Entry i arrives; hold it and start the inner walk at i + 1.
            krt_pkg::S_SORT_GETI: begin
                n_cur   = r_rdata;
                w_raddr = r_i + krt_pkg::IDX_BITS'(1);
                n_pos   = r_i + krt_pkg::IDX_BITS'(1);
                n_state = krt_pkg::S_SORT_SCAN;
            end

            // Entry j arrives; swap it with the held entry i when smaller.
            krt_pkg::S_SORT_SCAN: begin
                if (r_rdata.key < r_cur.key) begin
                    w_we    = 1'b1;
                    w_waddr = r_pos;
                    w_wdata = r_cur;
                    n_cur   = r_rdata;
                end
                if (w_pos_next < r_count) begin
                    w_raddr = w_pos_next[krt_pkg::IDX_BITS-1:0];
                    n_pos   = w_pos_next[krt_pkg::IDX_BITS-1:0];
                end else begin
                    n_state = krt_pkg::S_SORT_PUTI;
                end
            end

            // Write the settled entry i back and move to the next i, or finish the sort.
            krt_pkg::S_SORT_PUTI: begin
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = r_cur;
                if (w_i_next2 < r_count) begin
                    w_raddr = r_i + krt_pkg::IDX_BITS'(1);
                    n_i     = r_i + krt_pkg::IDX_BITS'(1);
                    n_state = krt_pkg::S_SORT_GETI;
                end else begin
                    n_sorted     = 1'b1;
                    n_res        = '0;
                    n_res.status = krt_pkg::STAT_OK;
                    n_state      = krt_pkg::S_RESP;
                end
            end

            // Linear search, one entry per cycle.
            krt_pkg::S_SRCH: begin
                n_res = '0;
                if (r_rdata.key == r_key) begin
                    n_res.status        = krt_pkg::STAT_OK;
                    n_res.found_index   = r_pos;
                    n_res.entry_key     = r_rdata.key;
                    n_res.entry_payload = r_rdata.payload;
                    n_state             = krt_pkg::S_RESP;
                end else if ((r_sorted && r_rdata.key > r_key) || w_pos_next >= r_count) begin
                    n_res.status = krt_pkg::STAT_MISS;
                    n_state      = krt_pkg::S_RESP;
                end else begin
                    w_raddr = w_pos_next[krt_pkg::IDX_BITS-1:0];
                    n_pos   = w_pos_next[krt_pkg::IDX_BITS-1:0];
                end
            end

            // Read data arrives for the requested index.
            krt_pkg::S_READ: begin
                n_res.status        = krt_pkg::STAT_OK;
                n_res.found_index   = r_pos;
                n_res.entry_key     = r_rdata.key;
                n_res.entry_payload = r_rdata.payload;
                n_state             = krt_pkg::S_RESP;
            end

            // Hand the result to the output register once it is free.
            krt_pkg::S_RESP: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = krt_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = krt_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // The entry count never passes the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= krt_pkg::CNT_BITS'(krt_pkg::TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    // The count only changes on an append taken in the idle state.
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != krt_pkg::S_IDLE) |=> (r_count == $past(r_count)))
        else $error("entry count changed while busy");

    // The search walk stays inside the filled part of the table.
    a_search_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == krt_pkg::S_SRCH) |-> ({1'b0, r_pos} < r_count))
        else $error("search position beyond entry count");

    // A completed sort leaves the table marked sorted.
    a_sort_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == krt_pkg::S_SORT_PUTI && w_i_next2 >= r_count) |=> r_sorted)
        else $error("sorted mark not set after sort");
`endif

endmodule
